### src/fpsc_pkg.sv
// ----------------------------------------------------------------------------
// fpsc_pkg
// shared types, codes and helpers for the frustum plane / sphere cull block
// ----------------------------------------------------------------------------
package fpsc_pkg;

  localparam int NumPlanes = 6;
  localparam logic [2:0] LastPlane = 3'(NumPlanes - 1);

  typedef logic signed [31:0] q16_t;

  typedef enum logic [1:0] {
    OP_LOAD_PROJ = 2'd0,
    OP_LOAD_MV   = 2'd1,
    OP_DERIVE    = 2'd2,
    OP_TEST      = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLIP_RD,
    S_CLIP_MUL,
    S_CLIP_ACC,
    S_CLIP_WR,
    S_PL_W,
    S_PL_N,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_PL_ZERO,
    S_DIV_GO,
    S_DIV_WAIT,
    S_T_MUL,
    S_T_ACC,
    S_T_CHK,
    S_DONE
  } state_t;

  // clamp a wide signed value into q16.16 range
  function automatic q16_t sat32(input logic signed [65:0] v);
    q16_t res;
    if (v[65:31] == {35{v[65]}}) begin
      res = v[31:0];
    end else if (v[65]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7fff_ffff;
    end
    return res;
  endfunction

  // clip column combined with column 3 for each plane
  function automatic logic [1:0] plane_col(input logic [2:0] p);
    logic [1:0] c;
    case (p)
      3'd0, 3'd1: c = 2'd0;
      3'd2, 3'd3: c = 2'd1;
      default:    c = 2'd2;
    endcase
    return c;
  endfunction

  // 1 when the plane adds its column, 0 when it subtracts
  function automatic logic plane_add(input logic [2:0] p);
    logic a;
    case (p)
      3'd1, 3'd2, 3'd5: a = 1'b1;
      default:          a = 1'b0;
    endcase
    return a;
  endfunction

endpackage

### src/frustum_plane_sphere_cull.sv
// ----------------------------------------------------------------------------
// frustum_plane_sphere_cull
// view frustum plane extraction and bounding sphere culling in q16.16
// ----------------------------------------------------------------------------
// usage
//   input stream: in_tuser carries the op (load projection element, load
//   modelview element, derive planes, test sphere), in_tdata the operands
//   output stream: one word per derive or test; out_tuser is the kind
//   loads give no word
//   derive: the clip matrix uses 64 products on the shared multiplier
//   (each read, multiplied and accumulated, 16 writebacks), then each of the
//   six planes runs three squares, a 32-step square root and four 48-step
//   divides, or stores zeros when the normal has zero length
//   test: per plane three products on the shared multiplier plus a compare,
//   then a result state; an early cull ends it
//   in_tready is high only while the sequencer is idle
//   a finished word sits in the output register; a new item is accepted
//   while it waits, and the next result holds in the done state until the
//   receiver takes the old one
//   reset clears the sequencer, the output valid and the plane store (all
//   zeros: a test before any derive with radius > 0 is visible, score = radius)
// ----------------------------------------------------------------------------
module frustum_plane_sphere_cull
  import fpsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // element_index[3:0], element_value[35:4], center_x[67:36],
  // center_y[99:68], center_z[131:100], sphere_radius[162:132], zero fill
  input  logic [167:0] in_tdata,
  // op[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // visible[0], score[32:1], degenerate[33], zero fill
  output logic [39:0]  out_tdata,
  // result_kind[0]
  output logic         out_tuser
);

  // input word fields
  op_t         in_op;
  logic [3:0]  in_idx;
  q16_t        in_val, in_cx, in_cy, in_cz;
  logic [30:0] in_rad;
  logic        in_fire;

  assign in_op   = op_t'(in_tuser);
  assign in_idx  = in_tdata[3:0];
  assign in_val  = in_tdata[35:4];
  assign in_cx   = in_tdata[67:36];
  assign in_cy   = in_tdata[99:68];
  assign in_cz   = in_tdata[131:100];
  assign in_rad  = in_tdata[162:132];
  assign in_fire = in_tvalid & in_tready;

  // sequencer state and loop counters
  state_t      state_r, state_nxt;
  logic [1:0]  k_r, k_nxt, i_r, i_nxt;
  logic [3:0]  e_r, e_nxt;
  logic [2:0]  p_r, p_nxt;

  // datapath registers
  logic signed [65:0] acc_r, acc_nxt;
  q16_t        w_r, w_nxt;
  q16_t        nv_r [4];
  logic        nv_we;
  q16_t        nv_wdata;
  logic [31:0] len_r, len_nxt;
  logic        degen_r, degen_nxt;
  q16_t        cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [30:0] rad_r, rad_nxt;
  logic        kind_r, kind_nxt, vis_r, vis_nxt;
  q16_t        score_r, score_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_vis_r, out_kind_r, out_degen_r, out_load;
  q16_t        out_score_r;

  // matrix memories, registered reads
  q16_t        pj_mem [16];
  q16_t        mv_mem [16];
  q16_t        pj_q_r, mv_q_r;
  logic [3:0]  pj_raddr, mv_raddr;
  logic        ld_pj, ld_mv;

  // clip matrix and plane store
  q16_t        clip_r [16];
  logic        clip_we;
  q16_t        clip_wdata, clip_rd;
  logic [3:0]  clip_raddr;
  q16_t        plane_r [24];
  logic        plane_we;
  logic [4:0]  plane_widx, plane_ridx;
  q16_t        plane_wdata, plane_rd;

  // shared units
  q16_t        mul_a, mul_b;
  logic signed [63:0] prod;
  logic        sq_start, sq_done, dv_start, dv_done;
  logic [31:0] sq_root;
  q16_t        dv_quo;

  // derived values
  logic signed [65:0] prod_ext, tsum;
  logic signed [32:0] n_raw;
  q16_t        ctr_sel;
  logic        culled, plane_last, i_last3;

  assign ld_pj = in_fire && (in_op == OP_LOAD_PROJ);
  assign ld_mv = in_fire && (in_op == OP_LOAD_MV);

  // clip[r][c] = sum over k of mv[r][k] * pj[k][c]
  assign mv_raddr = {e_r[3:2], k_r};
  assign pj_raddr = {k_r, e_r[1:0]};

  always_ff @(posedge clk) begin
    if (ld_pj) begin
      pj_mem[in_idx] <= in_val;
    end
    if (ld_mv) begin
      mv_mem[in_idx] <= in_val;
    end
    pj_q_r <= pj_mem[pj_raddr];
    mv_q_r <= mv_mem[mv_raddr];
  end

  // clip read: column 3 first, then the plane's own column
  assign clip_raddr = (state_r == S_PL_W) ? {i_r, 2'd3} : {i_r, plane_col(p_r)};
  assign clip_rd    = clip_r[clip_raddr];

  // plane read: normal components while multiplying, offset at the check
  assign plane_ridx = (state_r == S_T_CHK) ? {p_r, 2'd3} : {p_r, i_r};
  assign plane_rd   = plane_r[plane_ridx];

  assign prod_ext = {{2{prod[63]}}, prod};

  // raw plane component: w plus or minus the plane's column
  assign n_raw = plane_add(p_r) ? ({w_r[31], w_r} + {clip_rd[31], clip_rd})
                                : ({w_r[31], w_r} - {clip_rd[31], clip_rd});

  // distance plus radius; culled when that is not positive
  assign tsum   = (acc_r >>> 16) + $signed({{34{plane_rd[31]}}, plane_rd})
                + $signed({35'd0, rad_r});
  assign culled = tsum[65] | (tsum == '0);

  assign plane_last = (p_r == LastPlane);
  assign i_last3    = (i_r == 2'd3);

  always_comb begin
    case (i_r)
      2'd0:    ctr_sel = cx_r;
      2'd1:    ctr_sel = cy_r;
      default: ctr_sel = cz_r;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_CLIP_MUL: begin
        mul_a = mv_q_r;
        mul_b = pj_q_r;
      end
      S_SQ_MUL: begin
        mul_a = nv_r[i_r];
        mul_b = nv_r[i_r];
      end
      S_T_MUL: begin
        mul_a = plane_rd;
        mul_b = ctr_sel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fpsc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  assign sq_start = (state_r == S_SQRT_GO);
  assign dv_start = (state_r == S_DIV_GO);

  fpsc_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .value  (acc_r[63:0]),
    .done_r (sq_done),
    .root   (sq_root)
  );

  fpsc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dv_start),
    .num    (nv_r[i_r]),
    .den    (len_r),
    .done_r (dv_done),
    .quo    (dv_quo)
  );

  assign in_tready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_DERIVE: state_nxt = S_CLIP_RD;
            OP_TEST:   state_nxt = S_T_MUL;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLIP_RD:  state_nxt = S_CLIP_MUL;
      S_CLIP_MUL: state_nxt = S_CLIP_ACC;
      S_CLIP_ACC: state_nxt = (k_r == 2'd3) ? S_CLIP_WR : S_CLIP_RD;
      S_CLIP_WR:  state_nxt = (e_r == 4'd15) ? S_PL_W : S_CLIP_RD;
      S_PL_W:     state_nxt = S_PL_N;
      S_PL_N:     state_nxt = i_last3 ? S_SQ_MUL : S_PL_W;
      S_SQ_MUL:   state_nxt = S_SQ_ACC;
      S_SQ_ACC:   state_nxt = (i_r == 2'd2) ? S_SQRT_GO : S_SQ_MUL;
      S_SQRT_GO:  state_nxt = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (sq_done) begin
          state_nxt = (sq_root == '0) ? S_PL_ZERO : S_DIV_GO;
        end
      end
      S_PL_ZERO: begin
        if (i_last3) begin
          state_nxt = plane_last ? S_DONE : S_PL_W;
        end
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (dv_done) begin
          if (i_last3) begin
            state_nxt = plane_last ? S_DONE : S_PL_W;
          end else begin
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_T_MUL: state_nxt = S_T_ACC;
      S_T_ACC: state_nxt = (i_r == 2'd2) ? S_T_CHK : S_T_MUL;
      S_T_CHK: state_nxt = (culled || plane_last) ? S_DONE : S_T_MUL;
      S_DONE:  state_nxt = (!out_valid_r || out_tready) ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls and register next values
  always_comb begin
    k_nxt       = k_r;
    e_nxt       = e_r;
    p_nxt       = p_r;
    i_nxt       = i_r;
    acc_nxt     = acc_r;
    w_nxt       = w_r;
    len_nxt     = len_r;
    degen_nxt   = degen_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    cz_nxt      = cz_r;
    rad_nxt     = rad_r;
    kind_nxt    = kind_r;
    vis_nxt     = vis_r;
    score_nxt   = score_r;
    nv_we       = 1'b0;
    nv_wdata    = sat32({{33{n_raw[32]}}, n_raw});
    clip_we     = 1'b0;
    clip_wdata  = sat32(acc_r >>> 16);
    plane_we    = 1'b0;
    plane_widx  = {p_r, i_r};
    plane_wdata = '0;
    out_load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          k_nxt     = '0;
          e_nxt     = '0;
          p_nxt     = '0;
          i_nxt     = '0;
          acc_nxt   = '0;
          degen_nxt = 1'b0;
          cx_nxt    = in_cx;
          cy_nxt    = in_cy;
          cz_nxt    = in_cz;
          rad_nxt   = in_rad;
          kind_nxt  = (in_op == OP_TEST);
          vis_nxt   = 1'b0;
          score_nxt = '0;
        end
      end
      S_CLIP_ACC: begin
        acc_nxt = acc_r + prod_ext;
        k_nxt   = k_r + 2'd1;
      end
      S_CLIP_WR: begin
        clip_we = 1'b1;
        acc_nxt = '0;
        e_nxt   = e_r + 4'd1;
      end
      S_PL_W: begin
        w_nxt = clip_rd;
      end
      S_PL_N: begin
        nv_we = 1'b1;
        i_nxt = i_r + 2'd1;
        acc_nxt = '0;
      end
      S_SQ_ACC: begin
        acc_nxt = acc_r + prod_ext;
        i_nxt   = (i_r == 2'd2) ? 2'd0 : i_r + 2'd1;
      end
      S_SQRT_WAIT: begin
        if (sq_done) begin
          len_nxt = sq_root;
          i_nxt   = '0;
        end
      end
      S_PL_ZERO: begin
        // zero-length normal: plane stored as zeros
        plane_we  = 1'b1;
        degen_nxt = 1'b1;
        i_nxt     = i_r + 2'd1;
        if (i_last3) begin
          p_nxt = p_r + 3'd1;
        end
      end
      S_DIV_WAIT: begin
        if (dv_done) begin
          plane_we    = 1'b1;
          plane_wdata = dv_quo;
          i_nxt       = i_r + 2'd1;
          if (i_last3) begin
            p_nxt = p_r + 3'd1;
          end
        end
      end
      S_T_ACC: begin
        acc_nxt = acc_r + prod_ext;
        i_nxt   = (i_r == 2'd2) ? 2'd0 : i_r + 2'd1;
      end
      S_T_CHK: begin
        acc_nxt = '0;
        p_nxt   = p_r + 3'd1;
        if (!culled && plane_last) begin
          vis_nxt   = 1'b1;
          score_nxt = sat32(tsum);
        end
      end
      S_DONE: begin
        out_load = !out_valid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      e_r         <= '0;
      p_r         <= '0;
      i_r         <= '0;
      for (int j = 0; j < 24; j++) begin
        plane_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      e_r         <= e_nxt;
      p_r         <= p_nxt;
      i_r         <= i_nxt;
      if (plane_we) begin
        plane_r[plane_widx] <= plane_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    w_r     <= w_nxt;
    len_r   <= len_nxt;
    degen_r <= degen_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    rad_r   <= rad_nxt;
    kind_r  <= kind_nxt;
    vis_r   <= vis_nxt;
    score_r <= score_nxt;
    if (nv_we) begin
      nv_r[i_r] <= nv_wdata;
    end
    if (clip_we) begin
      clip_r[e_r] <= clip_wdata;
    end
    if (out_load) begin
      out_kind_r  <= kind_r;
      out_vis_r   <= vis_r;
      out_score_r <= score_r;
      out_degen_r <= !kind_r && degen_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_degen_r, out_score_r, out_vis_r};

endmodule

### src/fpsc_mul.sv
// ----------------------------------------------------------------------------
// fpsc_mul
// shared signed 32x32 multiplier with a registered product
// ----------------------------------------------------------------------------
module fpsc_mul
  import fpsc_pkg::*;
(
  input  logic               clk,
  input  q16_t               a,
  input  q16_t               b,
  output logic signed [63:0] prod_r
);

  logic signed [63:0] prod_nxt;

  assign prod_nxt = 64'(a) * 64'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

### src/fpsc_isqrt.sv
// ----------------------------------------------------------------------------
// fpsc_isqrt
// iterative 64-bit integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module fpsc_isqrt
  import fpsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done_r,
  output logic [31:0] root
);

  logic        run_r, run_nxt, done_nxt;
  logic [63:0] v_r, v_nxt, r_r, r_nxt, bit_r, bit_nxt, trial;

  assign trial = r_r + bit_r;
  assign root  = r_r[31:0];

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    v_nxt    = v_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    if (start) begin
      run_nxt = 1'b1;
      v_nxt   = value;
      r_nxt   = '0;
      bit_nxt = 64'd1 << 62;
    end else if (run_r) begin
      if (v_r >= trial) begin
        v_nxt = v_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 64'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

endmodule

### src/fpsc_div.sv
// ----------------------------------------------------------------------------
// fpsc_div
// restoring divider: (num * 65536) / den, truncated, clamped to q16.16
// ----------------------------------------------------------------------------
module fpsc_div
  import fpsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  q16_t        num,
  input  logic [31:0] den,
  output logic        done_r,
  output q16_t        quo
);

  logic        run_r, run_nxt, done_nxt, neg_r, neg_nxt, qbit;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt, den_r, den_nxt, mag;
  logic [32:0] rem_sh, diff;
  logic [47:0] n_r, n_nxt, q_r, q_nxt;
  logic signed [48:0] qs;

  assign mag    = num[31] ? 32'(-num) : 32'(num);
  assign rem_sh = {rem_r, n_r[47]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign qbit   = (rem_sh >= {1'b0, den_r});
  assign qs     = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign quo    = sat32({{17{qs[48]}}, qs});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = 6'd47;
      rem_nxt = '0;
      n_nxt   = {mag, 16'd0};
      q_nxt   = '0;
      den_nxt = den;
      neg_nxt = num[31];
    end else if (run_r) begin
      rem_nxt = qbit ? diff[31:0] : rem_sh[31:0];
      n_nxt   = {n_r[46:0], 1'b0};
      q_nxt   = {q_r[46:0], qbit};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

endmodule

### src/fpsc_checker.sv
// ----------------------------------------------------------------------------
// fpsc_checker
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
module fpsc_checker
  import fpsc_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [39:0]  out_tdata,
  input logic         out_tuser
);

  // stalled word stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // stalled word keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // derive words carry no visibility and no score
  a_derive_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[32:0] == 33'd0)
    else $error("derive word has test fields set");

  // test words never flag degenerate, culled ones score zero
  a_test_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[33] && (out_tdata[0] || out_tdata[32:1] == 32'd0))
    else $error("test word fields inconsistent");

  // a load never yields a word in the next cycle
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[1] && !out_tvalid |=> !out_tvalid)
    else $error("load produced a result word");

endmodule

bind frustum_plane_sphere_cull fpsc_checker u_fpsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### sim/tb_frustum_plane_sphere_cull.sv
// ----------------------------------------------------------------------------
// tb_frustum_plane_sphere_cull
// self-checking bench: loads matrices, derives planes and tests spheres while
// a software copy of the block predicts every output word
// ----------------------------------------------------------------------------
module tb_frustum_plane_sphere_cull;
  import fpsc_pkg::*;

  // one predicted output word
  typedef struct packed {
    logic        kind;
    logic        visible;
    logic [31:0] score;
    logic        degenerate;
  } cull_word_t;

  // software copy of the block state plus the queue of pending words
  class cull_scoreboard;
    logic signed [31:0] proj_m[16];
    logic signed [31:0] mv_m[16];
    logic signed [31:0] planes[24];
    cull_word_t pending[$];
    int errors;

    function new();
      errors = 0;
      foreach (proj_m[i]) begin
        proj_m[i] = 0;
        mv_m[i] = 0;
      end
      foreach (planes[i]) planes[i] = 0;
    endfunction

    function logic signed [63:0] clamp32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 64'sd2147483647;
      if (v < -128'sd2147483648) return -64'sd2147483648;
      return v[63:0];
    endfunction

    // floor of v / 65536
    function logic signed [127:0] floor16(logic signed [127:0] v);
      return v >>> 16;
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic derive();
      logic signed [31:0] clip[16];
      logic signed [127:0] acc;
      logic signed [63:0] n[4];
      logic signed [63:0] w;
      logic signed [63:0] e;
      logic [63:0] s;
      logic [63:0] len;
      logic degen;
      logic [1:0] col;
      degen = 0;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          acc = 0;
          for (int k = 0; k < 4; k++)
            acc += 128'(mv_m[r*4+k]) * 128'(proj_m[k*4+c]);
          clip[r*4+c] = 32'(clamp32(floor16(acc)));
        end
      for (int p = 0; p < 6; p++) begin
        // right/left use column 0, bottom/top column 1, far/near column 2
        col = (p < 2) ? 2'd0 : (p < 4) ? 2'd1 : 2'd2;
        for (int i = 0; i < 4; i++) begin
          w = clip[i*4+3];
          e = clip[i*4+col];
          n[i] = (p == 1 || p == 2 || p == 5) ? clamp32(128'(w + e)) : clamp32(128'(w - e));
        end
        s = 0;
        for (int i = 0; i < 3; i++) s += 64'(n[i] * n[i]);
        len = root64(s);
        if (len == 0) begin
          degen = 1;
          for (int i = 0; i < 4; i++) planes[p*4+i] = 0;
        end else begin
          for (int i = 0; i < 4; i++)
            planes[p*4+i] = 32'(clamp32((128'(n[i]) * 65536) / $signed({64'd0, len})));
        end
      end
      return degen;
    endfunction

    function void note_input(op_t op, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [30:0] rad);
      cull_word_t wd;
      logic signed [127:0] d;
      logic signed [127:0] ctr[3];
      logic vis;
      wd = '0;
      case (op)
        OP_LOAD_PROJ: proj_m[idx] = val;
        OP_LOAD_MV:   mv_m[idx] = val;
        OP_DERIVE: begin
          wd.degenerate = derive();
          pending.push_back(wd);
        end
        default: begin
          ctr[0] = 128'($signed(cx));
          ctr[1] = 128'($signed(cy));
          ctr[2] = 128'($signed(cz));
          vis = 1;
          d = 0;
          for (int p = 0; p < 6; p++) begin
            d = 0;
            for (int i = 0; i < 3; i++) d += 128'(planes[p*4+i]) * ctr[i];
            d = floor16(d) + 128'(planes[p*4+3]);
            if (d <= -$signed({97'd0, rad})) begin
              vis = 0;
              break;
            end
          end
          wd.kind = 1;
          wd.visible = vis;
          wd.score = vis ? 32'(clamp32(d + $signed({97'd0, rad}))) : 32'd0;
          pending.push_back(wd);
        end
      endcase
    endfunction

    function void check_result(logic kind, logic [39:0] data);
      cull_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected output word kind=%0d data=%h", kind, data);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (kind !== exp_w.kind) begin
        $error("result_kind expected %0d actual %0d", exp_w.kind, kind);
        errors++;
      end
      if (data[0] !== exp_w.visible) begin
        $error("visible expected %0d actual %0d", exp_w.visible, data[0]);
        errors++;
      end
      if (data[32:1] !== exp_w.score) begin
        $error("score expected %h actual %h", exp_w.score, data[32:1]);
        errors++;
      end
      if (data[33] !== exp_w.degenerate) begin
        $error("degenerate expected %0d actual %0d", exp_w.degenerate, data[33]);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;
  logic         out_tuser;

  cull_scoreboard sb;
  int  cycle_count;
  bit  no_idle;       // long stretch with no idling on either side
  bit  hold_off;      // receiver stalled for a long stretch
  // limit for the longest legal run, derives and stalls included; generous margin
  localparam int CycleLimit = 3_000_000;

  frustum_plane_sphere_cull u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL frustum_plane_sphere_cull");
      $finish;
    end
  end

  // result side: sample at rising edge, change ready at falling edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  always @(negedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if (no_idle) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 27);
  end

  // one long receiver stall so the output register and sequencer back up
  initial begin
    hold_off = 1'b0;
    @(posedge rst_n);
    repeat (3000) @(posedge clk);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    @(negedge clk);
    hold_off = 1'b0;
  end

  // offer one word, with random idle before it, and wait for acceptance
  task automatic send_word(op_t op, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [30:0] rad);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, rad, cz, cy, cx, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, idx, val, cx, cy, cz, rad);
  endtask

  task automatic load_elem(bit mv, logic [3:0] idx, logic [31:0] val);
    send_word(mv ? OP_LOAD_MV : OP_LOAD_PROJ, idx, val, $urandom, $urandom, $urandom,
              31'($urandom));
  endtask

  task automatic test_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [30:0] rad);
    send_word(OP_TEST, 4'($urandom), $urandom, cx, cy, cz, rad);
  endtask

  task automatic derive_now();
    send_word(OP_DERIVE, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
              31'($urandom));
  endtask

  // small matrix element: mostly near unit scale so planes are meaningful
  function automatic logic [31:0] rand_elem();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'sh0001_0000;
      2: return 32'sd0;
      default: return 32'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(5))
      0: return 31'($urandom);
      1: return 31'h7fff_ffff;
      2: return 31'd0;
      default: return 31'($urandom_range(1 << 20));
    endcase
  endfunction

  initial begin
    int n_items;
    sb = new();
    cycle_count = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = OP_LOAD_PROJ;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // test before any derive: reset planes, visible with score = radius if radius > 0
    test_sphere(32'h7fff_ffff, 32'h8000_0000, 32'd0, 31'h7fff_ffff);
    test_sphere(32'd0, 32'd0, 32'd0, 31'd0);
    // all-zero matrices give degenerate planes
    for (int i = 0; i < 16; i++) load_elem(1'b0, 4'(i), 32'd0);
    for (int i = 0; i < 16; i++) load_elem(1'b1, 4'(i), 32'd0);
    derive_now();
    // identity matrices: clean frustum
    for (int i = 0; i < 16; i++)
      load_elem(1'b0, 4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'd0);
    for (int i = 0; i < 16; i++)
      load_elem(1'b1, 4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'd0);
    derive_now();
    test_sphere(32'd0, 32'd0, 32'd0, 31'h0000_8000);
    test_sphere(32'h0005_0000, 32'd0, 32'd0, 31'h0000_1000);
    test_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    test_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0);
    // extreme elements for saturation
    for (int i = 0; i < 16; i++)
      load_elem(1'b0, 4'(i), (i & 1) ? 32'h8000_0000 : 32'h7fff_ffff);
    for (int i = 0; i < 16; i++) load_elem(1'b1, 4'(i), 32'h7fff_ffff);
    derive_now();
    test_sphere(32'h0001_0000, 32'hffff_0000, 32'd0, 31'h0001_0000);

    // random part: occasional full reloads + derive or single-element updates, then runs of tests
    n_items = 0;
    while (n_items < 1500) begin
      no_idle = (n_items > 600 && n_items < 800);
      if ($urandom_range(9) == 0) begin
        for (int i = 0; i < 16; i++) load_elem(1'b0, 4'(i), rand_elem());
        for (int i = 0; i < 16; i++) load_elem(1'b1, 4'(i), rand_elem());
        n_items += 32;
        derive_now();
        n_items++;
      end else if ($urandom_range(19) == 0) begin
        // partial update of one matrix element
        load_elem(1'($urandom_range(1)), 4'($urandom_range(15)), rand_elem());
        n_items++;
      end
      for (int t = $urandom_range(12); t > 0; t--) begin
        test_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius());
        n_items++;
      end
    end
    no_idle = 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS frustum_plane_sphere_cull");
    end else begin
      $display("FAIL frustum_plane_sphere_cull");
    end
    $finish;
  end

endmodule
